// ----- rtl/round_robin_quantum_scheduler_defines.svh -----
// assertion macros shared by the scheduler rtl
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define RRQS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RRQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rrqs_pkg.sv -----
// shared types and constants for the round-robin quantum scheduler
package rrqs_pkg;

  localparam int MAX_TASKS = 32;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_STEP  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] task_id;
    logic [15:0] task_len;
  } cmd_t;

  typedef struct packed {
    logic [15:0] served_id;
    logic [15:0] ran_for;
    logic        completed;
    logic        all_done;
    logic [31:0] elapsed;
  } result_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] remaining;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- rtl/rrqs_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module rrqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/round_robin_quantum_scheduler.sv -----
// round-robin scheduler: task table in ram, one entry read per cycle while scanning
// load, clear and unknown transactions are accepted without raising busy and give no result
// a step scans the table from the saved position, then writes back the served task and gives
//   its result; with no time left in any task or an empty table it gives an all-done result
// busy holds the next transaction until the result edge; the receiver cannot stall
// sync reset empties the table, zeroes position and elapsed time, quantum goes to 2
module round_robin_quantum_scheduler (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  rrqs_pkg::cmd_t          cmd,
  output logic                    done,
  output rrqs_pkg::result_t       result,
  input  logic                    quantum_we,
  input  logic [15:0]             quantum_wdata
);

  `include "round_robin_quantum_scheduler_defines.svh"

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    WRITE
  } state_t;

  state_t state;

  logic [15:0]                quantum;
  logic [rrqs_pkg::CNT_W-1:0] loaded_count;
  logic [rrqs_pkg::IDX_W-1:0] scan_position;
  logic [31:0]                time_total;

  // scan pipeline
  logic [rrqs_pkg::IDX_W-1:0] rd_idx;
  logic [rrqs_pkg::CNT_W-1:0] issued;
  logic                       chk_valid;
  logic                       chk_last;
  logic [rrqs_pkg::IDX_W-1:0] chk_idx;

  // selected entry
  logic [rrqs_pkg::IDX_W-1:0] hit_idx;
  logic [15:0]                hit_id;
  logic [15:0]                hit_rem;
  logic [15:0]                hit_run;

  logic                       ram_we;
  logic [rrqs_pkg::IDX_W-1:0] ram_waddr;
  rrqs_pkg::entry_t           ram_wdata;
  rrqs_pkg::entry_t           ram_rdata;
  logic [rrqs_pkg::ENTRY_W-1:0] ram_rdata_raw;

  logic                       accept;
  logic                       load_ok;
  logic [rrqs_pkg::IDX_W-1:0] start_pos;
  logic [15:0]                quantum_eff;
  logic                       hit;
  logic                       can_issue;
  logic [rrqs_pkg::IDX_W-1:0] rd_idx_next;
  logic [rrqs_pkg::IDX_W-1:0] scan_position_next;
  logic [15:0]                rem_left;

  assign busy   = (state != IDLE);
  assign accept = start && !busy;
  assign load_ok = accept && (cmd.action == rrqs_pkg::ACT_LOAD) &&
                   (loaded_count < rrqs_pkg::CNT_W'(rrqs_pkg::MAX_TASKS));

  // stale position falls back to entry 0
  assign start_pos = ({1'b0, scan_position} >= loaded_count) ? '0 : scan_position;
  assign quantum_eff = (quantum == 16'd0) ? 16'd1 : quantum;

  assign ram_rdata = rrqs_pkg::entry_t'(ram_rdata_raw);
  assign hit       = chk_valid && (ram_rdata.remaining != 16'd0);
  assign can_issue = (issued < loaded_count);

  assign rd_idx_next = ((rrqs_pkg::CNT_W'(rd_idx) + 1'b1) == loaded_count) ?
                       '0 : rd_idx + 1'b1;
  assign scan_position_next = ((rrqs_pkg::CNT_W'(hit_idx) + 1'b1) == loaded_count) ?
                              '0 : hit_idx + 1'b1;
  assign rem_left = hit_rem - hit_run;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = loaded_count[rrqs_pkg::IDX_W-1:0];
    ram_wdata = '{id: cmd.task_id, remaining: cmd.task_len};
    if (state == WRITE) begin
      ram_we    = 1'b1;
      ram_waddr = hit_idx;
      ram_wdata = '{id: hit_id, remaining: rem_left};
    end else if (load_ok) begin
      ram_we = 1'b1;
    end
  end

  rrqs_ram #(
    .WIDTH (rrqs_pkg::ENTRY_W),
    .DEPTH (rrqs_pkg::MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx),
    .rdata (ram_rdata_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      quantum       <= 16'd2;
      loaded_count  <= '0;
      scan_position <= '0;
      time_total    <= '0;
      chk_valid     <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (quantum_we) begin
        quantum <= quantum_wdata;
      end
      case (state)
        IDLE: begin
          if (load_ok) begin
            loaded_count <= loaded_count + 1'b1;
          end
          if (accept && (cmd.action == rrqs_pkg::ACT_CLEAR)) begin
            loaded_count  <= '0;
            scan_position <= '0;
            time_total    <= '0;
          end
          if (accept && (cmd.action == rrqs_pkg::ACT_STEP)) begin
            if (loaded_count == '0) begin
              done   <= 1'b1;
              result <= '{served_id: 16'd0, ran_for: 16'd0, completed: 1'b0,
                          all_done: 1'b1, elapsed: 32'd0};
            end else begin
              scan_position <= start_pos;
              rd_idx        <= start_pos;
              issued        <= '0;
              chk_valid     <= 1'b0;
              state         <= SCAN;
            end
          end
        end
        SCAN: begin
          if (hit) begin
            hit_idx   <= chk_idx;
            hit_id    <= ram_rdata.id;
            hit_rem   <= ram_rdata.remaining;
            hit_run   <= (ram_rdata.remaining < quantum_eff) ?
                         ram_rdata.remaining : quantum_eff;
            chk_valid <= 1'b0;
            state     <= WRITE;
          end else if (chk_valid && chk_last) begin
            // every loaded task is out of time
            done      <= 1'b1;
            result    <= '{served_id: 16'd0, ran_for: 16'd0, completed: 1'b0,
                           all_done: 1'b1, elapsed: 32'd0};
            chk_valid <= 1'b0;
            state     <= IDLE;
          end else begin
            chk_valid <= can_issue;
            chk_idx   <= rd_idx;
            chk_last  <= ((issued + 1'b1) == loaded_count);
            if (can_issue) begin
              rd_idx <= rd_idx_next;
              issued <= issued + 1'b1;
            end
          end
        end
        WRITE: begin
          time_total    <= time_total + {16'd0, hit_run};
          scan_position <= scan_position_next;
          done          <= 1'b1;
          result        <= '{served_id: hit_id, ran_for: hit_run,
                             completed: (rem_left == 16'd0), all_done: 1'b0,
                             elapsed: time_total + {16'd0, hit_run}};
          state         <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `RRQS_ASSERT_NOW(a_count_range, clk, rst, 1'b1, (loaded_count <= rrqs_pkg::CNT_W'(rrqs_pkg::MAX_TASKS)), "loaded count beyond table size")
  `RRQS_ASSERT_NOW(a_run_bounds, clk, rst, (state == WRITE), ((hit_run != 16'd0) && (hit_run <= hit_rem) && (hit_run <= quantum_eff)), "run time outside task and quantum bounds")
  `RRQS_ASSERT_NOW(a_all_done_zero, clk, rst, (done && result.all_done), ((result.served_id == 16'd0) && (result.ran_for == 16'd0) && !result.completed && (result.elapsed == 32'd0)), "all-done result carries nonzero fields")
  `RRQS_ASSERT_NOW(a_served_nonzero, clk, rst, (done && !result.all_done), (result.ran_for != 16'd0), "served task ran for zero time")
  `RRQS_ASSERT_NEXT(a_step_progress, clk, rst, (accept && (cmd.action == rrqs_pkg::ACT_STEP)), (busy || done), "step transaction neither scanning nor answered")

endmodule

// ----- dv/round_robin_quantum_scheduler_tb.sv -----
// self-checking testbench for the round-robin quantum scheduler
module round_robin_quantum_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrqs_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int QUIET_LIMIT   = 1000;
  localparam int STEP_LATENCY  = 3 + MAX_TASKS;
  localparam int SETTLE_CYCLES = 8;
  localparam int TARGET_ITEMS  = 1800;
  localparam int DIR_ROWS      = 18;

  typedef struct packed {
    cmd_t    c;
    logic    typed;
    result_t want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  cmd_t        cmd;
  logic        done;
  result_t     result;
  logic        quantum_we;
  logic [15:0] quantum_wdata;

  round_robin_quantum_scheduler u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .done          (done),
    .result        (result),
    .quantum_we    (quantum_we),
    .quantum_wdata (quantum_wdata)
  );

  // scheduler mirror
  logic [15:0] task_ids  [MAX_TASKS];
  logic [15:0] task_left [MAX_TASKS];
  int          tasks_loaded;
  int          rr_pos;
  logic [31:0] elapsed_total;
  logic [15:0] quantum;

  result_t     expected_results [$];
  int          errors;
  int          items_applied;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // 0: ignored, 1: state change only, 2: gives a result
  function automatic int predict_schedule(input cmd_t c, output result_t r);
    int          idx;
    logic [15:0] q;
    logic [15:0] run;
    r = '0;
    case (c.action)
      ACT_LOAD: begin
        if (tasks_loaded >= MAX_TASKS) return 0;
        task_ids[tasks_loaded]  = c.task_id;
        task_left[tasks_loaded] = c.task_len;
        tasks_loaded++;
        return 1;
      end
      ACT_CLEAR: begin
        tasks_loaded  = 0;
        rr_pos        = 0;
        elapsed_total = '0;
        return 1;
      end
      ACT_STEP: begin
        if (rr_pos >= tasks_loaded) rr_pos = 0;
        q = (quantum == 16'd0) ? 16'd1 : quantum;
        for (int k = 0; k < tasks_loaded; k++) begin
          idx = rr_pos + k;
          if (idx >= tasks_loaded) idx -= tasks_loaded;
          if (task_left[idx] != 16'd0) begin
            run = (task_left[idx] < q) ? task_left[idx] : q;
            task_left[idx] = task_left[idx] - run;
            elapsed_total  = elapsed_total + {16'd0, run};
            rr_pos = (idx + 1 >= tasks_loaded) ? 0 : idx + 1;
            r.served_id = task_ids[idx];
            r.ran_for   = run;
            r.completed = (task_left[idx] == 16'd0);
            r.all_done  = 1'b0;
            r.elapsed   = elapsed_total;
            return 2;
          end
        end
        r.all_done = 1'b1;
        return 2;
      end
      default: return 0;
    endcase
  endfunction

  function automatic logic [15:0] pick_burst(input int q_eff);
    if (q_eff >= 256 || $urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 4 * q_eff));
  endfunction

  task automatic send(input cmd_t c, output result_t r, output int kind);
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    kind = predict_schedule(c, r);
    if (kind != 0) items_applied++;
  endtask

  task automatic sender_idle(input bit no_gaps);
    int roll;
    int n;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) n = 0;
    else if (roll < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      cmd   <= {2'($urandom), 16'($urandom), 16'($urandom)};
    end
  endtask

  // hold the sender until every result is back and loads or clears have settled
  task automatic drain(input int tail);
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [15:0] v);
    @(negedge clk);
    quantum_we    <= 1'b1;
    quantum_wdata <= v;
    @(negedge clk);
    quantum_we    <= 1'b0;
    quantum = v;
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: served_id %0h elapsed %0h", result.served_id,
                 result.elapsed);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (result.served_id !== want.served_id) begin
            $error("served_id: expected %0h, got %0h", want.served_id, result.served_id);
            errors++;
          end
          if (result.ran_for !== want.ran_for) begin
            $error("ran_for: expected %0h, got %0h", want.ran_for, result.ran_for);
            errors++;
          end
          if (result.completed !== want.completed) begin
            $error("completed: expected %0b, got %0b", want.completed, result.completed);
            errors++;
          end
          if (result.all_done !== want.all_done) begin
            $error("all_done: expected %0b, got %0b", want.all_done, result.all_done);
            errors++;
          end
          if (result.elapsed !== want.elapsed) begin
            $error("elapsed: expected %0h, got %0h", want.elapsed, result.elapsed);
            errors++;
          end
        end
      end
      if ((start && !busy) || done || quantum_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t    dir_tab [DIR_ROWS];
    result_t     r;
    cmd_t        c;
    int          kind;
    int          ep;
    int          n_load;
    int          n_steps;
    int          needed;
    int          q_eff;
    int          roll;
    bit          no_gaps;
    logic [15:0] qv;

    rst           = 1'b1;
    start         = 1'b0;
    cmd           = '0;
    quantum_we    = 1'b0;
    quantum_wdata = '0;
    errors        = 0;
    items_applied = 0;
    tasks_loaded  = 0;
    rr_pos        = 0;
    elapsed_total = '0;
    quantum       = 16'd2;
    for (int i = 0; i < MAX_TASKS; i++) begin
      task_ids[i]  = '0;
      task_left[i] = '0;
    end

    // empty table, ignored action, extremes, zero burst, reset quantum of 2
    dir_tab[0]  = {ACT_STEP,   16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b1, 32'd0};
    dir_tab[1]  = {ACT_UNUSED, 16'hffff, 16'hffff, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0};
    dir_tab[2]  = {ACT_LOAD,   16'hffff, 16'hffff, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0};
    dir_tab[3]  = {ACT_LOAD,   16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0};
    dir_tab[4]  = {ACT_LOAD,   16'h1234, 16'h0001, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0};
    dir_tab[5]  = {ACT_STEP,   16'h0000, 16'h0000, 1'b1, 16'hffff, 16'h0002, 1'b0, 1'b0, 32'd2};
    dir_tab[6]  = {ACT_STEP,   16'h0000, 16'h0000, 1'b1, 16'h1234, 16'h0001, 1'b1, 1'b0, 32'd3};
    dir_tab[7]  = {ACT_STEP,   16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0};
    dir_tab[8]  = {ACT_CLEAR,  16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0};
    dir_tab[9]  = {ACT_STEP,   16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b1, 32'd0};
    dir_tab[10] = {ACT_LOAD,   16'h0007, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0};
    dir_tab[11] = {ACT_STEP,   16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b1, 32'd0};
    dir_tab[12] = {ACT_LOAD,   16'haaaa, 16'h0002, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0};
    dir_tab[13] = {ACT_STEP,   16'h0000, 16'h0000, 1'b1, 16'haaaa, 16'h0002, 1'b1, 1'b0, 32'd2};
    dir_tab[14] = {ACT_STEP,   16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b1, 32'd0};
    dir_tab[15] = {ACT_LOAD,   16'h5555, 16'h5555, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0};
    dir_tab[16] = {ACT_STEP,   16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0};
    dir_tab[17] = {ACT_CLEAR,  16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send(dir_tab[i].c, r, kind);
      if (dir_tab[i].typed) expected_results.push_back(dir_tab[i].want);
      else if (kind == 2) expected_results.push_back(r);
      sender_idle(1'b0);
    end
    drain(SETTLE_CYCLES);

    items_applied = 0;
    ep = 0;
    while (items_applied < TARGET_ITEMS) begin
      // quantum only changes with the scheduler idle
      if (ep < 5 || $urandom_range(0, 3) == 0) begin
        case (ep)
          0: qv = 16'd1;
          1: qv = 16'hffff;
          2: qv = 16'd0;
          3: qv = 16'd3;
          default: begin
            roll = $urandom_range(0, 9);
            if (roll < 6) qv = 16'($urandom_range(1, 8));
            else if (roll < 8) qv = 16'($urandom_range(9, 300));
            else qv = 16'($urandom);
          end
        endcase
        drain(SETTLE_CYCLES);
        write_quantum(qv);
      end
      q_eff   = (quantum == 16'd0) ? 1 : int'(quantum);
      no_gaps = ($urandom_range(0, 3) == 0);

      if ($urandom_range(0, 9) != 0) begin
        c = '0;
        c.action = ACT_CLEAR;
        send(c, r, kind);
        sender_idle(no_gaps);
      end

      // mostly short task lists, sometimes past the table capacity
      n_load = ($urandom_range(0, 6) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
      repeat (n_load) begin
        c.action   = ACT_LOAD;
        c.task_id  = 16'($urandom);
        c.task_len = pick_burst(q_eff);
        send(c, r, kind);
        sender_idle(no_gaps);
      end

      needed = 0;
      for (int i = 0; i < tasks_loaded; i++) needed += (int'(task_left[i]) + q_eff - 1) / q_eff;
      n_steps = ((needed > 60) ? 60 : needed) + $urandom_range(0, 3);

      repeat (n_steps) begin
        roll = $urandom_range(0, 99);
        c.task_id  = 16'($urandom);
        c.task_len = pick_burst(q_eff);
        if (roll < 4) c.action = ACT_LOAD;
        else if (roll < 7) begin
          c.action   = ACT_UNUSED;
          c.task_len = 16'($urandom);
        end else if (roll < 8) c.action = ACT_CLEAR;
        else c.action = ACT_STEP;
        send(c, r, kind);
        if (kind == 2) expected_results.push_back(r);
        sender_idle(no_gaps);
      end
      ep++;
    end

    drain(STEP_LATENCY);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
